// File: design/met_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
`timescale 1ns / 1ps

package met_pkg;

    // Default internal coordinate width (signed, 4 integer bits).
    localparam int COORD_WIDTH_DEF = 32;

    // Fixed field widths.
    localparam int REG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 12;
    localparam int SIZE_W    = 13;
    localparam int ITER_W    = 17;
    localparam int SHADE_W   = 8;

    // Digit width of the partial-product multipliers.
    localparam int DIGIT_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN      = 3'd0,
        CFG_X_MAX      = 3'd1,
        CFG_Y_MIN      = 3'd2,
        CFG_Y_MAX      = 3'd3,
        CFG_WIDTH      = 3'd4,
        CFG_HEIGHT     = 3'd5,
        CFG_ITER_LIMIT = 3'd6
    } t_cfg_idx;

    localparam logic [REG_W-1:0]  RST_X_MIN  = 32'hE000_0000;
    localparam logic [REG_W-1:0]  RST_X_MAX  = 32'h2000_0000;
    localparam logic [REG_W-1:0]  RST_Y_MIN  = 32'hE000_0000;
    localparam logic [REG_W-1:0]  RST_Y_MAX  = 32'h2000_0000;
    localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [ITER_W-1:0] RST_LIMIT  = 17'd100000;

    typedef struct packed {
        logic load_in;
        logic map_start;
        logic map_sel_y;
        logic store_c;
        logic mul_start;
        logic advance;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic map_done;
        logic mul_done;
        logic finish;
        logic out_free;
    } t_sts;

endpackage

// File: design/met_mul.sv
// Signed fixed-point multiplier: digit-serial partial products, shift and saturation.
`timescale 1ns / 1ps

module met_mul #(
    parameter int W = met_pkg::COORD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_dbl,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_p,
    output logic         o_done
);

    localparam int F     = W - 4;
    localparam int DW    = met_pkg::DIGIT_W;
    localparam int ND    = (W + DW - 1) / DW;
    localparam int PB    = ND * DW;
    localparam int ACC_W = W + PB;
    localparam int KW    = (ND > 1) ? $clog2(ND) : 1;

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (W - 1);
    localparam logic [W-1:0]     MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     MINV = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_SAT} t_phase;

    t_phase           r_phase;
    logic             r_done;
    logic [KW-1:0]    r_cnt;
    logic [W-1:0]     r_ma;
    logic [PB-1:0]    r_mb;
    logic             r_neg;
    logic             r_dbl;
    logic [ACC_W-1:0] r_acc;
    logic [W-1:0]     r_p;

    logic [W-1:0]       mag_a;
    logic [W-1:0]       mag_b;
    logic [DW-1:0]      digit;
    logic [W+DW-1:0]    pp;
    logic [ACC_W-1:0]   n_acc;
    logic [ACC_W-1:0]   sh;

    assign mag_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign digit = r_mb[PB-1 -: DW];
    assign pp    = r_ma * digit;
    assign n_acc = (r_acc << DW) + ACC_W'(pp);
    assign sh    = r_dbl ? (r_acc >> (F - 1)) : (r_acc >> F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                M_IDLE: begin
                    if (i_start) begin
                        r_ma    <= mag_a;
                        r_mb    <= PB'(mag_b);
                        r_neg   <= i_a[W-1] ^ i_b[W-1];
                        r_dbl   <= i_dbl;
                        r_acc   <= '0;
                        r_cnt   <= KW'(ND - 1);
                        r_phase <= M_RUN;
                    end
                end
                M_RUN: begin
                    // Horner step: most significant digit first.
                    r_acc <= n_acc;
                    r_mb  <= r_mb << DW;
                    if (r_cnt == '0) begin
                        r_phase <= M_SAT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                M_SAT: begin
                    if (r_neg) begin
                        r_p <= (sh > HALF) ? MINV : (~sh[W-1:0] + 1'b1);
                    end else begin
                        r_p <= (sh > (HALF - 1'b1)) ? MAXV : sh[W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_phase <= M_IDLE;
                end
                default: begin
                    r_phase <= M_IDLE;
                end
            endcase
        end
    end

    assign o_p    = r_p;
    assign o_done = r_done;

endmodule

// File: design/met_map.sv
// Pixel to coordinate mapper: serial multiply, bit-serial divide, saturating offset.
`timescale 1ns / 1ps

module met_map #(
    parameter int W = met_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [met_pkg::REG_W-1:0]   i_mn_raw,
    input  logic [met_pkg::REG_W-1:0]   i_mx_raw,
    input  logic [met_pkg::PIX_W-1:0]   i_index,
    input  logic [met_pkg::SIZE_W-1:0]  i_size,
    output logic [W-1:0]                o_c,
    output logic                        o_done
);

    localparam int RW = met_pkg::REG_W;
    localparam int PW = met_pkg::PIX_W;
    localparam int SW = met_pkg::SIZE_W;
    localparam int QW = W + PW;
    localparam int CW = $clog2(QW);

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {P_IDLE, P_PREP, P_MUL, P_DIV, P_SAT} t_phase;

    t_phase          r_phase;
    logic            r_done;
    logic [RW-1:0]   r_mn_raw;
    logic [RW-1:0]   r_mx_raw;
    logic [PW-1:0]   r_mplier;
    logic [SW-1:0]   r_div;
    logic [W-1:0]    r_mn;
    logic            r_neg;
    logic [W-1:0]    r_lim_pos;
    logic [W-1:0]    r_lim_neg;
    logic [QW-1:0]   r_mcand;
    logic [QW-1:0]   r_acc;
    logic [SW-1:0]   r_rem;
    logic [CW-1:0]   r_cnt;
    logic [W-1:0]    r_c;

    logic [W-1:0]    mn_w;
    logic [W-1:0]    mx_w;
    logic [W:0]      diff;
    logic [W:0]      dmag;
    logic [W:0]      lim_pos;
    logic [W:0]      lim_neg;
    logic [SW:0]     trial;
    logic            ge;
    logic [SW:0]     rem_sub;
    logic [W-1:0]    lim;
    logic            over;
    logic [W-1:0]    offs;

    // Scale Q4.28 registers to the internal format.
    generate
        if (W > RW) begin : g_wide
            assign mn_w = {r_mn_raw, {(W-RW){1'b0}}};
            assign mx_w = {r_mx_raw, {(W-RW){1'b0}}};
        end else if (W == RW) begin : g_same
            assign mn_w = r_mn_raw;
            assign mx_w = r_mx_raw;
        end else begin : g_narrow
            assign mn_w = r_mn_raw[RW-1 -: W];
            assign mx_w = r_mx_raw[RW-1 -: W];
        end
    endgenerate

    assign diff    = {mx_w[W-1], mx_w} - {mn_w[W-1], mn_w};
    assign dmag    = diff[W] ? (~diff + 1'b1) : diff;
    assign lim_pos = {1'b0, MAXV} - {mn_w[W-1], mn_w};
    assign lim_neg = {mn_w[W-1], mn_w} - {1'b1, MINV};

    assign trial   = {r_rem, r_acc[QW-1]};
    assign ge      = (trial >= {1'b0, r_div});
    assign rem_sub = ge ? (trial - {1'b0, r_div}) : trial;

    assign lim  = r_neg ? r_lim_neg : r_lim_pos;
    assign over = (r_acc > QW'(lim));
    assign offs = r_neg ? (r_mn - r_acc[W-1:0]) : (r_mn + r_acc[W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_mn_raw <= i_mn_raw;
                        r_mx_raw <= i_mx_raw;
                        r_mplier <= i_index;
                        // A zero size divides by one.
                        r_div    <= (i_size == '0) ? SW'(1) : i_size;
                        r_phase  <= P_PREP;
                    end
                end
                P_PREP: begin
                    r_mn      <= mn_w;
                    r_neg     <= diff[W];
                    r_lim_pos <= lim_pos[W-1:0];
                    r_lim_neg <= lim_neg[W-1:0];
                    r_mcand   <= QW'(dmag[W-1:0]);
                    r_acc     <= '0;
                    r_cnt     <= CW'(PW - 1);
                    r_phase   <= P_MUL;
                end
                P_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == '0) begin
                        r_cnt   <= CW'(QW - 1);
                        r_rem   <= '0;
                        r_phase <= P_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                P_DIV: begin
                    // Restoring division; quotient bits shift in as dividend bits leave.
                    r_rem <= rem_sub[SW-1:0];
                    r_acc <= {r_acc[QW-2:0], ge};
                    if (r_cnt == '0) begin
                        r_phase <= P_SAT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                P_SAT: begin
                    if (over) begin
                        r_c <= r_neg ? MINV : MAXV;
                    end else begin
                        r_c <= offs;
                    end
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    assign o_c    = r_c;
    assign o_done = r_done;

endmodule

// File: design/met_dp.sv
// Datapath: configuration registers, coordinate mapping, z iteration and result register.
`timescale 1ns / 1ps

module met_dp #(
    parameter int W = met_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [met_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [met_pkg::REG_W-1:0]      i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic [met_pkg::PIX_W-1:0]      i_column,
    input  logic [met_pkg::PIX_W-1:0]      i_row,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [met_pkg::PIX_W-1:0]      o_out_column,
    output logic [met_pkg::PIX_W-1:0]      o_out_row,
    output logic [met_pkg::ITER_W-1:0]     o_iterations,
    output logic [met_pkg::SHADE_W-1:0]    o_shade,
    input  met_pkg::t_cmd                  i_cmd,
    output met_pkg::t_sts                  o_sts
);

    localparam int RW = met_pkg::REG_W;
    localparam int PW = met_pkg::PIX_W;
    localparam int SW = met_pkg::SIZE_W;
    localparam int IW = met_pkg::ITER_W;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] FOUR = W'(1) << (W - 2);

    logic [RW-1:0] r_x_min;
    logic [RW-1:0] r_x_max;
    logic [RW-1:0] r_y_min;
    logic [RW-1:0] r_y_max;
    logic [SW-1:0] r_width;
    logic [SW-1:0] r_height;
    logic [IW-1:0] r_limit;
    logic          r_cfg_ready;

    logic [PW-1:0] r_col;
    logic [PW-1:0] r_row;
    logic [W-1:0]  r_cr;
    logic [W-1:0]  r_ci;
    logic [W-1:0]  r_zr;
    logic [W-1:0]  r_zi;
    logic [IW-1:0] r_n;

    logic          r_out_valid;
    logic [PW-1:0] r_out_col;
    logic [PW-1:0] r_out_row;
    logic [IW-1:0] r_out_iter;

    logic [W-1:0]  map_c;
    logic          map_done;
    logic [W-1:0]  p_ri;
    logic [W-1:0]  p_rr;
    logic [W-1:0]  p_ii;
    logic          done_ri;
    logic          done_rr;
    logic          done_ii;
    logic [W-1:0]  lsq;
    logic [W-1:0]  n_zr;
    logic [W-1:0]  n_zi;

    function automatic logic [W-1:0] f_sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? MINV : MAXV;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? MINV : MAXV;
        end
        return s[W-1:0];
    endfunction

    // Configuration registers; ready comes up in the cycle after reset is released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min     <= met_pkg::RST_X_MIN;
            r_x_max     <= met_pkg::RST_X_MAX;
            r_y_min     <= met_pkg::RST_Y_MIN;
            r_y_max     <= met_pkg::RST_Y_MAX;
            r_width     <= met_pkg::RST_WIDTH;
            r_height    <= met_pkg::RST_HEIGHT;
            r_limit     <= met_pkg::RST_LIMIT;
            r_cfg_ready <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                case (met_pkg::t_cfg_idx'(i_cfg_index))
                    met_pkg::CFG_X_MIN:      r_x_min  <= i_cfg_data;
                    met_pkg::CFG_X_MAX:      r_x_max  <= i_cfg_data;
                    met_pkg::CFG_Y_MIN:      r_y_min  <= i_cfg_data;
                    met_pkg::CFG_Y_MAX:      r_y_max  <= i_cfg_data;
                    met_pkg::CFG_WIDTH:      r_width  <= i_cfg_data[SW-1:0];
                    met_pkg::CFG_HEIGHT:     r_height <= i_cfg_data[SW-1:0];
                    met_pkg::CFG_ITER_LIMIT: r_limit  <= i_cfg_data[IW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    met_map #(.W(W)) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.map_start),
        .i_mn_raw (i_cmd.map_sel_y ? r_y_min : r_x_min),
        .i_mx_raw (i_cmd.map_sel_y ? r_y_max : r_x_max),
        .i_index  (i_cmd.map_sel_y ? r_row : r_col),
        .i_size   (i_cmd.map_sel_y ? r_height : r_width),
        .o_c      (map_c),
        .o_done   (map_done)
    );

    // 2*zr*zi uses one less bit of shift.
    met_mul #(.W(W)) u_mul_ri (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_dbl   (1'b1),
        .i_a     (r_zr),
        .i_b     (r_zi),
        .o_p     (p_ri),
        .o_done  (done_ri)
    );

    met_mul #(.W(W)) u_mul_rr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_dbl   (1'b0),
        .i_a     (r_zr),
        .i_b     (r_zr),
        .o_p     (p_rr),
        .o_done  (done_rr)
    );

    met_mul #(.W(W)) u_mul_ii (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_dbl   (1'b0),
        .i_a     (r_zi),
        .i_b     (r_zi),
        .o_p     (p_ii),
        .o_done  (done_ii)
    );

    assign lsq  = f_sat_add(p_rr, p_ii);
    assign n_zr = f_sat_add(f_sat_sub(p_rr, p_ii), r_cr);
    assign n_zi = f_sat_add(p_ri, r_ci);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_column;
            r_row <= i_row;
            r_zr  <= '0;
            r_zi  <= '0;
            r_n   <= '0;
        end else if (i_cmd.advance) begin
            r_zr <= n_zr;
            r_zi <= n_zi;
            r_n  <= r_n + IW'(1);
        end
        if (i_cmd.store_c) begin
            if (i_cmd.map_sel_y) begin
                r_ci <= map_c;
            end else begin
                r_cr <= map_c;
            end
        end
        if (i_cmd.emit) begin
            r_out_col  <= r_col;
            r_out_row  <= r_row;
            r_out_iter <= r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.map_done = map_done;
    assign o_sts.mul_done = done_ri & done_rr & done_ii;
    assign o_sts.finish   = (r_n >= r_limit) || ($signed(lsq) >= $signed(FOUR));
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_cfg_ready  = r_cfg_ready;
    assign o_valid      = r_out_valid;
    assign o_out_column = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_iterations = r_out_iter;
    assign o_shade      = r_out_iter[met_pkg::SHADE_W-1:0];

endmodule

// File: design/met_ctrl.sv
// Controller: sequences mapping, multiply and update steps for one pixel at a time.
`timescale 1ns / 1ps

module met_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  met_pkg::t_sts i_sts,
    output met_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAPX_GO,
        S_MAPX_WAIT,
        S_MAPY_GO,
        S_MAPY_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_STEP,
        S_DONE
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_stall;
    met_pkg::t_cmd c_cmd;

    always_comb begin
        n_state = r_state;
        c_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_stall) begin
                    c_cmd.load_in = 1'b1;
                    n_state       = S_MAPX_GO;
                end
            end
            S_MAPX_GO: begin
                c_cmd.map_start = 1'b1;
                n_state         = S_MAPX_WAIT;
            end
            S_MAPX_WAIT: begin
                if (i_sts.map_done) begin
                    c_cmd.store_c = 1'b1;
                    n_state       = S_MAPY_GO;
                end
            end
            S_MAPY_GO: begin
                c_cmd.map_sel_y = 1'b1;
                c_cmd.map_start = 1'b1;
                n_state         = S_MAPY_WAIT;
            end
            S_MAPY_WAIT: begin
                c_cmd.map_sel_y = 1'b1;
                if (i_sts.map_done) begin
                    c_cmd.store_c = 1'b1;
                    n_state       = S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                c_cmd.mul_start = 1'b1;
                n_state         = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (i_sts.finish) begin
                    n_state = S_DONE;
                end else begin
                    c_cmd.advance = 1'b1;
                    n_state       = S_MUL_GO;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    c_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;
    assign o_cmd   = c_cmd;

endmodule

// File: design/mandelbrot_escape_time_core.sv
// Top level of the Mandelbrot escape-time engine.
//
// Input channel: i_valid / o_stall carry one pixel beat (i_column, i_row).
// Output channel: o_valid / i_stall carry one result beat per pixel
// (o_out_column, o_out_row, o_iterations, o_shade = iterations mod 256).
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// write only while no pixel is in flight. Indexes beyond 6 are dropped.
// One pixel is worked at a time. W = COORD_WIDTH and ND = ceil(W/16).
// The next pixel beat is taken in the cycle after the result is loaded, so
// the block takes no new pixel until the last one is finished.
// Setup is set by the shared mapper (12-step multiply, (W+12)-step divide);
// the loop is set by the three digit-serial multipliers (ND digits each).
// A finished result waits in the output register while the next pixel is
// already accepted and worked; if the receiver still stalls when that pixel
// is done, hold it until the output register frees.
// Reset (synchronous, active low) clears control state and loads the default
// view (-2..2 on both axes, 640 x 480, limit 100000); o_stall drops and
// o_cfg_ready rises in the cycle after reset is released.
`timescale 1ns / 1ps

module mandelbrot_escape_time_core #(
    parameter int COORD_WIDTH = met_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [met_pkg::REG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [met_pkg::PIX_W-1:0]      i_column,
    input  logic [met_pkg::PIX_W-1:0]      i_row,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [met_pkg::PIX_W-1:0]      o_out_column,
    output logic [met_pkg::PIX_W-1:0]      o_out_row,
    output logic [met_pkg::ITER_W-1:0]     o_iterations,
    output logic [met_pkg::SHADE_W-1:0]    o_shade
);

    // Commands from the controller and status back from the datapath.
    met_pkg::t_cmd cmd;
    met_pkg::t_sts sts;

    met_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath owns configuration, coordinate mapping, iteration and result beat.
    met_dp #(.W(COORD_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_iterations (o_iterations),
        .o_shade      (o_shade),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

// File: design/met_checker.sv
// Port-level assertions for the escape-time engine, bound to the top level.
`timescale 1ns / 1ps

module met_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [met_pkg::PIX_W-1:0]     o_out_column,
    input logic [met_pkg::PIX_W-1:0]     o_out_row,
    input logic [met_pkg::ITER_W-1:0]    o_iterations,
    input logic [met_pkg::SHADE_W-1:0]   o_shade
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_column) && $stable(o_out_row)
            && $stable(o_iterations) && $stable(o_shade))
        else $error("result beat changed while stalled");

    // Shade is the low byte of the iteration count.
    a_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_shade == o_iterations[met_pkg::SHADE_W-1:0]))
        else $error("shade does not match iteration count");

    // One pixel at a time: an accepted beat makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted while a pixel is in flight");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time_core met_checker u_met_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_column (o_out_column),
    .o_out_row    (o_out_row),
    .o_iterations (o_iterations),
    .o_shade      (o_shade)
);

// File: sim/testbench.sv
// Self-checking testbench for mandelbrot_escape_time_core: fixed-point escape-time prediction.
`timescale 1ns / 1ps

module testbench;
    import met_pkg::*;

    // Register index the block has no register for; a write to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // Q4.28 coordinate format at the default COORD_WIDTH of 32.
    localparam int     FRAC_Q     = 28;
    localparam int     ONE_Q      = 1 << FRAC_Q;
    localparam longint COORD_MAX  = (64'sd1 <<< 31) - 1;
    localparam longint COORD_MIN  = -(64'sd1 <<< 31);
    localparam longint FOUR_Q     = 64'sd1 <<< 30;

    localparam int RST_CYCLES     = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 300;
    localparam int HOLD_AT        = 24;
    localparam int LONG_HOLD      = 3000;

    typedef enum logic [1:0] {JOB_PIXEL, JOB_WRITE, JOB_DRAIN} job_kind_e;

    typedef struct packed {
        job_kind_e              kind;
        logic [PIX_W-1:0]       column;
        logic [PIX_W-1:0]       row;
        logic [CFG_IDX_W-1:0]   index;
        logic [REG_W-1:0]       data;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0]   column;
        logic [PIX_W-1:0]   row;
        logic [ITER_W-1:0]  iterations;
        logic [SHADE_W-1:0] shade;
    } pixel_result_t;

    typedef enum logic [2:0] {
        DRV_IDLE, DRV_GAP, DRV_PIXEL, DRV_SETTLE, DRV_WRITE, DRV_DRAIN
    } drv_state_e;

    // DUT ports; the inputs are driven to known values from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [PIX_W-1:0]     i_column    = '0;
    logic [PIX_W-1:0]     i_row       = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [PIX_W-1:0]     o_out_column;
    logic [PIX_W-1:0]     o_out_row;
    logic [ITER_W-1:0]    o_iterations;
    logic [SHADE_W-1:0]   o_shade;

    // Shadow copy of the view registers, updated on every accepted write beat.
    logic [REG_W-1:0]  view_x_min  = RST_X_MIN;
    logic [REG_W-1:0]  view_x_max  = RST_X_MAX;
    logic [REG_W-1:0]  view_y_min  = RST_Y_MIN;
    logic [REG_W-1:0]  view_y_max  = RST_Y_MAX;
    logic [SIZE_W-1:0] view_width  = RST_WIDTH;
    logic [SIZE_W-1:0] view_height = RST_HEIGHT;
    logic [ITER_W-1:0] view_limit  = RST_LIMIT;

    job_t          job_q[$];
    pixel_result_t pending_results[$];

    // Beat flags captured at the rising edge, consumed at the next falling edge.
    logic pix_beat = 1'b0;
    logic cfg_beat = 1'b0;
    logic res_beat = 1'b0;

    drv_state_e drv_state = DRV_IDLE;
    job_t       cur_job   = '0;
    int         gap_left  = 0;
    int         pix_sent  = 0;
    logic       tx_quiet  = 1'b0;

    int   stall_left   = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;
    logic rx_quiet     = 1'b0;
    int   results_seen = 0;

    int fail_count = 0;
    int idle_cycles = 0;

    mandelbrot_escape_time_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_iterations (o_iterations),
        .o_shade      (o_shade)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Escape-time predictor, Q4.28 with saturation on every sum and product
    // ---------------------------------------------------------------------

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Multiply magnitudes at full width, drop sh fraction bits (truncate
    // toward zero), then reapply the sign and saturate.
    function automatic longint fx_mul(longint a, longint b, int sh);
        longint ma, mb, prod;
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = (ma * mb) >>> sh;
        return clamp_coord(((a < 0) != (b < 0)) ? -prod : prod);
    endfunction

    // Map a pixel index onto one axis: min + index*(max-min)/size, with the
    // quotient magnitude truncated and a zero size taken as one.
    function automatic longint map_axis(logic [REG_W-1:0] lo_q, logic [REG_W-1:0] hi_q,
                                        logic [PIX_W-1:0] idx, logic [SIZE_W-1:0] npix);
        longint mn, mx, divisor, step;
        mn      = int'(lo_q);
        mx      = int'(hi_q);
        divisor = (npix == 0) ? 64'sd1 : longint'(npix);
        if (mx >= mn) begin
            step = ((mx - mn) * longint'(idx)) / divisor;
            return clamp_coord(mn + step);
        end
        step = ((mn - mx) * longint'(idx)) / divisor;
        return clamp_coord(mn - step);
    endfunction

    function automatic int unsigned escape_count(longint cr, longint ci, int unsigned lim);
        longint      zr, zi, zr2, zi2, mag2, next_r;
        int unsigned n;
        zr = 0; zi = 0; zr2 = 0; zi2 = 0; mag2 = 0; n = 0;
        while (n < lim && mag2 < FOUR_Q) begin
            next_r = clamp_coord(clamp_coord(zr2 - zi2) + cr);
            zi     = clamp_coord(fx_mul(zr, zi, FRAC_Q - 1) + ci);
            zr     = next_r;
            zr2    = fx_mul(zr, zr, FRAC_Q);
            zi2    = fx_mul(zi, zi, FRAC_Q);
            mag2   = clamp_coord(zr2 + zi2);
            n++;
        end
        return n;
    endfunction

    function automatic pixel_result_t predict_pixel(logic [PIX_W-1:0] col,
                                                    logic [PIX_W-1:0] row);
        pixel_result_t res;
        int unsigned   n;
        n = escape_count(map_axis(view_x_min, view_x_max, col, view_width),
                         map_axis(view_y_min, view_y_max, row, view_height),
                         view_limit);
        res.column     = col;
        res.row        = row;
        res.iterations = n[ITER_W-1:0];
        res.shade      = n[SHADE_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------------

    task automatic push_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        job_t j;
        j        = '0;
        j.kind   = JOB_PIXEL;
        j.column = col;
        j.row    = row;
        job_q.push_back(j);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        job_t j;
        j       = '0;
        j.kind  = JOB_WRITE;
        j.index = idx;
        j.data  = data;
        job_q.push_back(j);
    endtask

    task automatic push_drain();
        job_t j;
        j      = '0;
        j.kind = JOB_DRAIN;
        job_q.push_back(j);
    endtask

    // Write the whole view; every write waits for the block to go idle.
    task automatic set_view(input logic [REG_W-1:0] x0, input logic [REG_W-1:0] x1,
                            input logic [REG_W-1:0] y0, input logic [REG_W-1:0] y1,
                            input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [ITER_W-1:0] lim);
        push_write(CFG_X_MIN, x0);
        push_write(CFG_X_MAX, x1);
        push_write(CFG_Y_MIN, y0);
        push_write(CFG_Y_MAX, y1);
        push_write(CFG_WIDTH, REG_W'(w));
        push_write(CFG_HEIGHT, REG_W'(h));
        push_write(CFG_ITER_LIMIT, REG_W'(lim));
    endtask

    // ---------------------------------------------------------------------
    // Sample all channels at the rising edge: predict on each pixel beat,
    // track register writes, check each result beat against the oldest
    // expectation.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        pixel_result_t want;
        if (i_rst_n) begin
            pix_beat <= i_valid && !o_stall;
            cfg_beat <= i_cfg_valid && o_cfg_ready;
            res_beat <= o_valid && !i_stall;

            if (i_valid && !o_stall)
                pending_results.push_back(predict_pixel(i_column, i_row));

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_MIN:      view_x_min  <= i_cfg_data;
                    CFG_X_MAX:      view_x_max  <= i_cfg_data;
                    CFG_Y_MIN:      view_y_min  <= i_cfg_data;
                    CFG_Y_MAX:      view_y_max  <= i_cfg_data;
                    CFG_WIDTH:      view_width  <= i_cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:     view_height <= i_cfg_data[SIZE_W-1:0];
                    CFG_ITER_LIMIT: view_limit  <= i_cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end

            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with no pixel pending, column %0d row %0d",
                             $time, o_out_column, o_out_row);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_column", want.column, o_out_column);
                    check_field("out_row", want.row, o_out_row);
                    check_field("iterations", want.iterations, o_iterations);
                    check_field("shade", want.shade, o_shade);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Driver: advance through the job queue at the falling edge. Pixels get
    // a random gap before valid rises; writes and drains hold until every
    // expected result is back. Each input sees exactly one assignment here.
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((drv_state == DRV_PIXEL && pix_beat) || (drv_state == DRV_WRITE && cfg_beat)) begin
                drv_state = DRV_IDLE;
            end else if (drv_state == DRV_GAP) begin
                gap_left--;
                if (gap_left == 0)
                    drv_state = DRV_PIXEL;
            end else if (drv_state == DRV_SETTLE && pending_results.size() == 0) begin
                drv_state = DRV_WRITE;
            end else if (drv_state == DRV_DRAIN && pending_results.size() == 0) begin
                drv_state = DRV_IDLE;
            end

            if (drv_state == DRV_IDLE && job_q.size() != 0) begin
                cur_job = job_q.pop_front();
                case (cur_job.kind)
                    JOB_PIXEL: begin
                        gap_left = tx_quiet ? 0 : $urandom_range(0, 10);
                        pix_sent++;
                        // Switch between gappy and back-to-back stretches.
                        if (pix_sent % 16 == 0)
                            tx_quiet = ($urandom_range(0, 2) == 0);
                        drv_state = (gap_left == 0) ? DRV_PIXEL : DRV_GAP;
                    end
                    JOB_WRITE: drv_state = DRV_SETTLE;
                    default:   drv_state = DRV_DRAIN;
                endcase
            end
        end
        i_valid     <= (drv_state == DRV_PIXEL);
        i_column    <= cur_job.column;
        i_row       <= cur_job.row;
        i_cfg_valid <= (drv_state == DRV_WRITE);
        i_cfg_index <= cur_job.index;
        i_cfg_data  <= cur_job.data;
    end

    // ---------------------------------------------------------------------
    // Receiver: after each result beat draw a random stall, with quiet
    // stretches. Once, hold stall for a long run so the block fills
    // up and pushes back on the pixel channel.
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (res_beat) begin
            stall_left = rx_quiet ? 0 : $urandom_range(0, 10);
            if (results_seen % 20 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
        end else if (stall_left != 0) begin
            stall_left--;
        end

        if (!hold_done && results_seen == HOLD_AT) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
        end
        i_stall <= (stall_left != 0) || (hold_left != 0);
    end

    // Watchdog: count cycles with no beat on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (i_cfg_valid && o_cfg_ready) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("mandelbrot_escape_time_core verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Job list, reset and end of run
    // ---------------------------------------------------------------------
    initial begin
        int                phase, k;
        logic [REG_W-1:0]  x0, x1, y0, y1, span, swap;
        logic [SIZE_W-1:0] w, h;
        logic [ITER_W-1:0] lim;
        logic [PIX_W-1:0]  col, row;

        // Reset view: corners of the pixel range, all far outside the set.
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd4095, 12'd4095);
        push_pixel(12'd0, 12'd4095);
        push_pixel(12'd4095, 12'd0);

        // Zero sizes act as one; a zero limit yields no iterations.
        set_view(-2 * ONE_Q, 2 * ONE_Q, -2 * ONE_Q, 2 * ONE_Q, 13'd0, 13'd0, 17'd0);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd1, 12'd1);

        // Sizes above 4096; points inside the set run past 256 so the shade wraps.
        set_view(-2 * ONE_Q, ONE_Q, -3 * ONE_Q / 2, 3 * ONE_Q / 2, 13'd8191, 13'd8191,
                 17'd300);
        push_pixel(12'd4095, 12'd4095);
        push_pixel(12'd2048, 12'd2048);

        // Full-range bounds, reversed on y, one-pixel image: indexes past the
        // size saturate, every point escapes at once, so the top limit is safe.
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 13'd1, 13'd1, 17'd131071);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd1, 12'd1);
        push_pixel(12'd4095, 12'd4095);
        push_pixel(12'd0, 12'd4095);

        // Limit of one.
        set_view(-5 * ONE_Q / 2, ONE_Q, -5 * ONE_Q / 4, 5 * ONE_Q / 4, 13'd64, 13'd48, 17'd1);
        push_pixel(12'd32, 12'd24);
        push_pixel(12'd63, 12'd47);

        // Reversed bounds on both axes, then a write to an unused index that
        // must leave the view alone.
        set_view(ONE_Q, -2 * ONE_Q, 5 * ONE_Q / 4, -5 * ONE_Q / 4, 13'd16, 13'd16, 17'd40);
        push_write(CFG_UNUSED_IDX, 32'h0000_0001);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd15, 12'd15);
        push_pixel(12'd8, 12'd8);
        push_pixel(12'd12, 12'd8);

        // Random views around the set, one phase with raw random bounds.
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 3) begin
                x0 = $urandom;
                x1 = $urandom;
                y0 = $urandom;
                y1 = $urandom;
            end else begin
                x0   = -2 * ONE_Q + $urandom_range(0, 2 * ONE_Q);
                span = $urandom_range(ONE_Q / 64, 3 * ONE_Q);
                x1   = x0 + span;
                y0   = -3 * ONE_Q / 2 + $urandom_range(0, 3 * ONE_Q / 2);
                span = $urandom_range(ONE_Q / 64, 3 * ONE_Q);
                y1   = y0 + span;
                if ($urandom_range(0, 3) == 0) begin
                    swap = x0; x0 = x1; x1 = swap;
                end
                if ($urandom_range(0, 3) == 0) begin
                    swap = y0; y0 = y1; y1 = swap;
                end
            end
            w   = SIZE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 64));
            h   = SIZE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 64));
            lim = ITER_W'((phase == 2) ? $urandom_range(200, 400) : $urandom_range(1, 200));
            set_view(x0, x1, y0, y1, w, h, lim);

            for (k = 0; k < 17; k++) begin
                // Let the pipeline run dry once per phase.
                if (k == 11)
                    push_drain();
                if (w == 0 || w > 4096 || $urandom_range(0, 3) == 0)
                    col = PIX_W'($urandom_range(0, 4095));
                else
                    col = PIX_W'($urandom_range(0, w - 1));
                if (h == 0 || h > 4096 || $urandom_range(0, 3) == 0)
                    row = PIX_W'($urandom_range(0, 4095));
                else
                    row = PIX_W'($urandom_range(0, h - 1));
                push_pixel(col, row);
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (job_q.size() != 0 || drv_state != DRV_IDLE || pending_results.size() != 0);

        // Give a stray result time to show up.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("mandelbrot_escape_time_core verification clean");
        else
            $display("mandelbrot_escape_time_core verification failed");
        $finish;
    end

endmodule
